// ----- sv/priority_task_queue_with_deferral_core_assert.svh -----
// Assertion macros used by the core RTL file of the task queue.
`ifndef PRIORITY_TASK_QUEUE_WITH_DEFERRAL_CORE_ASSERT_SVH
`define PRIORITY_TASK_QUEUE_WITH_DEFERRAL_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define PTQD_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`define PTQD_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define PTQD_ASSERT_IMP(label, pre, post, msg)

`define PTQD_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ----- sv/ptqd_pkg.sv -----
package ptqd_pkg;

   localparam int LEVEL_DEPTH = 16;
   localparam int NUM_LEVELS  = 5;

   localparam int LEVEL_W   = 3;
   localparam int TAG_W     = 16;
   localparam int TOKEN_W   = 16;
   localparam int STATUS_W  = 4;
   localparam int PEND_W    = 7;
   localparam int DEFER_W   = 6;
   localparam int CSR_IDX_W = 1;

   localparam int IDX_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int TOTAL_W = CNT_W + 3;
   localparam int SLOTS  = NUM_LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);

   localparam logic [LEVEL_W-1:0] LVL_REALTIME   = 3'd0;
   localparam logic [LEVEL_W-1:0] LVL_ELEVATED   = 3'd1;
   localparam logic [LEVEL_W-1:0] LVL_NORMAL     = 3'd2;
   localparam logic [LEVEL_W-1:0] LVL_BACKGROUND = 3'd3;
   localparam logic [LEVEL_W-1:0] LVL_IDLE       = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_THERMAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY = 1'b1;

   typedef enum logic [1:0] {
      CMD_SUBMIT,
      CMD_RUN_NEXT,
      CMD_BURST_START,
      CMD_BURST_END
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED,
      ST_DEFERRED,
      ST_REJ_THERMAL,
      ST_REJ_BATTERY,
      ST_DISPATCHED,
      ST_EMPTY,
      ST_BURST_ON,
      ST_BURST_OFF,
      ST_FULL
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ
   } state_type;

   typedef struct packed {
      logic               tok_ok;
      logic [TOKEN_W-1:0] token;
      logic [TAG_W-1:0]   tag;
   } task_entry_type;

   localparam int ENTRY_W = $bits(task_entry_type);

   function automatic logic level_eligible(logic [LEVEL_W-1:0] lv, logic burst);
      return (lv < LVL_BACKGROUND) || !burst;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(logic [LEVEL_W-1:0] lv,
                                                   logic [IDX_W-1:0] pos);
      return ADDR_W'(lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(pos);
   endfunction

endpackage

// ----- sv/ptqd_task_ram.sv -----
module ptqd_task_ram #(
   parameter int DEPTH = 80,
   parameter int WIDTH = 33
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ----- sv/priority_task_queue_with_deferral_core.sv -----
// Strict-priority task queue with five levels and burst deferral.
// Input channel (req_*): one item carries a command, a priority level and a
// task tag; it is accepted when req_valid is high and req_stall is low.
// Result channel (rsp_*): every item yields exactly one result, held in an
// output register until rsp_valid is high and rsp_stall is low.
// The csr_* port writes the thermal throttle and battery flags at any edge
// with csr_write_enable high; use it only while the block is idle (unchecked).
// Tasks live in one synchronous RAM of five rings of LEVEL_DEPTH entries.
// An item is latched at its accepting edge and executed in state S_EXEC once
// the output register is free; submits, burst commands and empty dispatches
// load their result there, while a dispatch that finds a task first reads
// the head entry from the RAM and loads its result in state S_READ. A new
// item is accepted only in S_IDLE, once the block is through with the last.
// One item is in work at a time; the input register takes the next item
// while an earlier result still waits on the output register.
// A stalled receiver holds the result; the block then finishes latching one
// more item and waits with it until the output register is free.
// Synchronous reset empties all levels, clears the burst flag, the token
// counter and both flags; the RAM contents are left undefined, since only
// written entries are ever read.
`include "priority_task_queue_with_deferral_core_assert.svh"

module priority_task_queue_with_deferral_core
   import ptqd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic [LEVEL_W-1:0]   req_priority_level,
   input  logic [TAG_W-1:0]     req_task_tag,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_token_valid,
   output logic [TOKEN_W-1:0]   rsp_token_id,
   output logic [TAG_W-1:0]     rsp_dispatched_tag,
   output logic [LEVEL_W-1:0]   rsp_dispatched_level,
   output logic [PEND_W-1:0]    rsp_pending_count,
   output logic [DEFER_W-1:0]   rsp_deferred_count,
   output logic                 rsp_burst_active,

   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_write_data
);

   state_type            state_ff, state_in;
   command_type          cmd_ff;
   logic [LEVEL_W-1:0]   lv_ff, lv_in;
   logic [TAG_W-1:0]     tag_ff;
   logic [LEVEL_W-1:0]   sel_lv_ff, sel_lv_in;

   logic [IDX_W-1:0]     head_ff  [NUM_LEVELS];
   logic [IDX_W-1:0]     head_in  [NUM_LEVELS];
   logic [CNT_W-1:0]     count_ff [NUM_LEVELS];
   logic [CNT_W-1:0]     count_in [NUM_LEVELS];
   logic                 burst_ff, burst_in;
   logic [TOKEN_W-1:0]   token_ff, token_in;
   logic                 thermal_ff, battery_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, res_status;
   logic                 rsp_tv_ff, res_tv;
   logic [TOKEN_W-1:0]   rsp_tid_ff, res_tid;
   logic [TAG_W-1:0]     rsp_dtag_ff, res_dtag;
   logic [LEVEL_W-1:0]   rsp_dlv_ff, res_dlv;
   logic [PEND_W-1:0]    rsp_pend_ff, res_pend;
   logic [DEFER_W-1:0]   rsp_defer_ff, res_defer;
   logic                 rsp_burst_ff;
   logic                 rsp_load;

   logic                 req_accept;
   logic                 out_free;
   logic                 found;
   logic [LEVEL_W-1:0]   found_lv;
   logic                 defer;
   logic [SUM_W-1:0]     pos_sum;
   logic [IDX_W-1:0]     tail_pos;

   logic                 ram_we, ram_re;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   task_entry_type       ram_wdata, ram_rdata;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign lv_in = (req_priority_level > LVL_IDLE) ? LVL_IDLE : req_priority_level;

   always_comb begin
      found    = 1'b0;
      found_lv = LVL_REALTIME;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (!found && level_eligible(LEVEL_W'(l), burst_ff) && (count_ff[l] != '0)) begin
            found    = 1'b1;
            found_lv = LEVEL_W'(l);
         end
      end
   end

   assign defer    = burst_ff && (lv_ff >= LVL_BACKGROUND);
   assign pos_sum  = SUM_W'(head_ff[lv_ff]) + SUM_W'(count_ff[lv_ff]);
   assign tail_pos = (pos_sum >= SUM_W'(LEVEL_DEPTH)) ?
                     IDX_W'(pos_sum - SUM_W'(LEVEL_DEPTH)) : IDX_W'(pos_sum);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = ((cmd_ff == CMD_RUN_NEXT) && found) ? S_READ : S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      logic [TOTAL_W-1:0] pend_sum;
      logic [TOTAL_W-1:0] defer_sum;

      head_in    = head_ff;
      count_in   = count_ff;
      burst_in   = burst_ff;
      token_in   = token_ff;
      sel_lv_in  = sel_lv_ff;
      ram_we     = 1'b0;
      ram_waddr  = slot_addr(lv_ff, tail_pos);
      ram_wdata  = '{tok_ok: 1'b0, token: '0, tag: tag_ff};
      ram_re     = 1'b0;
      ram_raddr  = slot_addr(found_lv, head_ff[found_lv]);
      rsp_load   = 1'b0;
      res_status = ST_EMPTY;
      res_tv     = 1'b0;
      res_tid    = '0;
      res_dtag   = '0;
      res_dlv    = '0;

      unique case (state_ff)
         S_EXEC: begin
            if (out_free) begin
               unique case (cmd_ff)
                  CMD_SUBMIT: begin
                     rsp_load = 1'b1;
                     priority if (!defer && thermal_ff && (lv_ff >= LVL_BACKGROUND)) begin
                        res_status = ST_REJ_THERMAL;
                     end else if (!defer && battery_ff && (lv_ff == LVL_IDLE)) begin
                        res_status = ST_REJ_BATTERY;
                     end else if (count_ff[lv_ff] >= CNT_W'(LEVEL_DEPTH)) begin
                        res_status = ST_FULL;
                     end else begin
                        ram_we          = 1'b1;
                        count_in[lv_ff] = count_ff[lv_ff] + CNT_W'(1);
                        if (defer) begin
                           res_status = ST_DEFERRED;
                        end else begin
                           ram_wdata  = '{tok_ok: 1'b1, token: token_ff, tag: tag_ff};
                           token_in   = token_ff + TOKEN_W'(1);
                           res_status = ST_QUEUED;
                           res_tv     = 1'b1;
                           res_tid    = token_ff;
                        end
                     end
                  end
                  CMD_RUN_NEXT: begin
                     if (found) begin
                        ram_re             = 1'b1;
                        sel_lv_in          = found_lv;
                        head_in[found_lv]  = (head_ff[found_lv] == IDX_W'(LEVEL_DEPTH - 1)) ?
                                             '0 : head_ff[found_lv] + IDX_W'(1);
                        count_in[found_lv] = count_ff[found_lv] - CNT_W'(1);
                     end else begin
                        rsp_load   = 1'b1;
                        res_status = ST_EMPTY;
                     end
                  end
                  CMD_BURST_START: begin
                     rsp_load   = 1'b1;
                     burst_in   = 1'b1;
                     token_in   = token_ff + TOKEN_W'(1);
                     res_status = ST_BURST_ON;
                     res_tv     = 1'b1;
                     res_tid    = token_ff;
                  end
                  CMD_BURST_END: begin
                     rsp_load   = 1'b1;
                     burst_in   = 1'b0;
                     res_status = ST_BURST_OFF;
                  end
                  default: begin
                     rsp_load = 1'b0;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_load   = 1'b1;
            res_status = ST_DISPATCHED;
            res_tv     = ram_rdata.tok_ok;
            res_tid    = ram_rdata.tok_ok ? ram_rdata.token : '0;
            res_dtag   = ram_rdata.tag;
            res_dlv    = sel_lv_ff;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase

      pend_sum = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (level_eligible(LEVEL_W'(l), burst_in)) begin
            pend_sum = pend_sum + TOTAL_W'(count_in[l]);
         end
      end
      defer_sum = burst_in ?
                  TOTAL_W'(count_in[LVL_BACKGROUND]) + TOTAL_W'(count_in[LVL_IDLE]) : '0;
      res_pend  = PEND_W'(pend_sum);
      res_defer = DEFER_W'(defer_sum);
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         burst_ff     <= 1'b0;
         token_ff     <= '0;
         thermal_ff   <= 1'b0;
         battery_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         burst_ff     <= burst_in;
         token_ff     <= token_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_THERMAL: thermal_ff <= csr_write_data;
               CSR_BATTERY: battery_ff <= csr_write_data;
               default:     thermal_ff <= thermal_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= command_type'(req_command);
         lv_ff  <= lv_in;
         tag_ff <= req_task_tag;
      end
      sel_lv_ff <= sel_lv_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status;
         rsp_tv_ff     <= res_tv;
         rsp_tid_ff    <= res_tid;
         rsp_dtag_ff   <= res_dtag;
         rsp_dlv_ff    <= res_dlv;
         rsp_pend_ff   <= res_pend;
         rsp_defer_ff  <= res_defer;
         rsp_burst_ff  <= burst_in;
      end
   end

   ptqd_task_ram #(
      .DEPTH (SLOTS),
      .WIDTH (ENTRY_W)
   ) u_task_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_enable   (ram_re),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_token_valid      = rsp_tv_ff;
   assign rsp_token_id         = rsp_tid_ff;
   assign rsp_dispatched_tag   = rsp_dtag_ff;
   assign rsp_dispatched_level = rsp_dlv_ff;
   assign rsp_pending_count    = rsp_pend_ff;
   assign rsp_deferred_count   = rsp_defer_ff;
   assign rsp_burst_active     = rsp_burst_ff;

   `PTQD_ASSERT_IMP(a_read_after_exec, state_ff == S_READ, $past(state_ff) == S_EXEC, "RAM read state entered from a state other than execute")
   `PTQD_ASSERT_IMP(a_read_slot_free, state_ff == S_READ, !rsp_valid_ff, "Dispatch read finished while the output register was still full")
   `PTQD_ASSERT_NEXT(a_exec_waits, (state_ff == S_EXEC) && !out_free, state_ff == S_EXEC, "Item left execute while the output register was blocked")

endmodule
